// ----- hw/rtl/prrts_pkg.sv -----
`default_nettype none
package prrts_pkg;

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_EXEC   = 3'd1,
    MODE_FORK   = 3'd2,
    MODE_WAIT   = 3'd3,
    MODE_SIGNAL = 3'd4,
    MODE_EXIT   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NO_SLOT = 2'd2,
    ST_NO_RUN  = 2'd3
  } status_t;

  localparam logic CFG_QUANTUM     = 1'b0;
  localparam logic CFG_EVENT_COUNT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SIG_WALK,
    S_RS_TICK,
    S_BEST,
    S_RS_DECIDE,
    S_QBACK,
    S_QFRONT,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/priority_round_robin_thread_scheduler.sv -----
`default_nettype none
// Preemptive priority round-robin thread scheduler.
// s_axis carries one scheduler event per item: tdata = {event_req[13:6],
// priority_req[5:3], mode[2:0]} plus two zero pad bits. m_axis returns one
// result per event: tdata = {status[11:10], value[9:5], running_valid[4],
// running_thread[3:0]} plus four zero pad bits.
// cfg_* writes the quantum length (index 0) and event_count (index 1).
// A rejected event goes straight from decode to the result; a valid
// event runs through a small sequencer that steps through queue edits, a
// priority scan that checks one ready queue per cycle, and a signal walk
// that moves one blocked thread per cycle. One event is in flight at a
// time, so a new item is taken only after the last result is loaded.
// While m_axis_tready is low the result holds; the next event is still
// taken and worked on, and the sequencer waits in its last step until the
// result register is free.
// Reset empties all queues and lists, clears the started flag and sets the
// quantum length to 1 and event_count to 0; per-thread tables need no clearing.
module priority_round_robin_thread_scheduler
  import prrts_pkg::*;
#(
  parameter int MaxPrio    = 5,
  parameter int MaxEvents  = 16,
  parameter int MaxThreads = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // mode[2:0] priority_req[5:3] event_req[13:6]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0] m_axis_tdata, // running_thread[3:0] running_valid[4] value[9:5] status[11:10]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);
  localparam int IdW = $clog2(MaxThreads + 1);
  localparam int TW  = $clog2(MaxThreads);
  localparam int PW  = $clog2(MaxPrio + 2);
  localparam int EW  = (MaxEvents > 1) ? $clog2(MaxEvents) : 1;
  localparam logic [IdW-1:0] Nil = IdW'(MaxThreads);

  logic [7:0] slice_len;
  logic [4:0] event_count;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_len   <= 8'd1;
      event_count <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_QUANTUM) slice_len <= cfg_data;
      else event_count <= cfg_data[4:0];
    end
  end

  logic [2:0] thread_priority [MaxThreads];
  logic [7:0] thread_ticks_left [MaxThreads];
  logic [IdW-1:0] next_link [MaxThreads];
  logic [IdW-1:0] ready_head [MaxPrio+1];
  logic [IdW-1:0] ready_tail [MaxPrio+1];
  logic [IdW-1:0] event_head [MaxEvents];

  state_t state;
  logic [2:0] mode;
  logic [2:0] preq;
  logic [7:0] ereq;
  logic [IdW-1:0] current_id, next_free_id, walk, lose;
  logic current_valid, started, expired, after_wait;
  logic [IdW-1:0] value;
  status_t status;

  logic [MaxPrio:0] nonempty;
  logic best_go, best_busy, best_found;
  logic [PW-1:0] best_prio;
  for (genvar g = 0; g <= MaxPrio; g++) begin : g_ne
    assign nonempty[g] = ready_head[g] != Nil;
  end

  prrts_best #(.MaxPrio(MaxPrio)) u_best (
    .clk, .rst, .go(best_go), .nonempty,
    .busy(best_busy), .found(best_found), .prio(best_prio)
  );

  logic ev_ok;
  assign ev_ok = ({1'b0, ereq} < {4'd0, event_count}) && (32'(ereq) < MaxEvents);
  logic [EW-1:0] ev_i;
  assign ev_i = EW'(ereq);
  logic [TW-1:0] cur_i;
  assign cur_i = TW'(current_id);

  function automatic logic [PW-1:0] clip(input logic [2:0] p);
    return (32'(p) > MaxPrio) ? PW'(MaxPrio) : PW'(p);
  endfunction

  logic [PW-1:0] walk_p, lose_p;
  logic [IdW-1:0] cand;
  assign walk_p = clip(thread_priority[TW'(walk)]);
  assign lose_p = clip(thread_priority[TW'(lose)]);
  assign cand   = ready_head[best_prio];

  logic res_load;
  assign res_load = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  assign s_axis_tready = (state == S_IDLE);
  assign best_go = (state == S_RS_TICK) ||
                   (state == S_DECODE && started && current_valid &&
                    ((mode == MODE_WAIT && ev_ok) || mode == MODE_EXIT));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {4'd0, status, 5'(value),
                        current_valid, current_valid ? 4'(current_id) : 4'd0};
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      started       <= 1'b0;
      current_valid <= 1'b0;
      current_id    <= '0;
      next_free_id  <= '0;
      for (int i = 0; i <= MaxPrio; i++) begin
        ready_head[i] <= Nil;
        ready_tail[i] <= Nil;
      end
      for (int i = 0; i < MaxEvents; i++) event_head[i] <= Nil;
    end else begin
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          mode       <= s_axis_tdata[2:0];
          preq       <= s_axis_tdata[5:3];
          ereq       <= s_axis_tdata[13:6];
          after_wait <= (s_axis_tdata[2:0] == MODE_WAIT) ||
                        (s_axis_tdata[2:0] == MODE_EXIT);
          value      <= '0;
          status     <= ST_OK;
          state      <= S_DECODE;
        end
        S_DECODE: begin
          if (mode == MODE_START) begin
            if (started || slice_len == 0 || 32'(event_count) > MaxEvents) begin
              status <= ST_INVALID;
              state  <= S_DONE;
            end else begin
              started <= 1'b1;
              thread_priority[0] <= '0;
              thread_ticks_left[0] <= slice_len;
              next_link[0] <= Nil;
              current_id <= '0;
              current_valid <= 1'b1;
              next_free_id <= IdW'(1);
              state <= S_RS_TICK;
            end
          end else if (!started || mode > MODE_EXIT) begin
            status <= ST_INVALID;
            state  <= S_DONE;
          end else if (!current_valid) begin
            status <= ST_NO_RUN;
            state  <= S_DONE;
          end else begin
            unique case (mode)
              MODE_EXEC: state <= S_RS_TICK;
              MODE_FORK: begin
                if (32'(preq) > MaxPrio) begin
                  status <= ST_INVALID;
                  state  <= S_DONE;
                end else if (32'(next_free_id) >= MaxThreads) begin
                  status <= ST_NO_SLOT;
                  state  <= S_DONE;
                end else begin
                  thread_priority[TW'(next_free_id)] <= preq;
                  thread_ticks_left[TW'(next_free_id)] <= slice_len;
                  next_link[TW'(next_free_id)] <= Nil;
                  if (ready_head[clip(preq)] == Nil) ready_head[clip(preq)] <= next_free_id;
                  else next_link[TW'(ready_tail[clip(preq)])] <= next_free_id;
                  ready_tail[clip(preq)] <= next_free_id;
                  value <= next_free_id;
                  next_free_id <= next_free_id + 1'b1;
                  state <= S_RS_TICK;
                end
              end
              MODE_WAIT: begin
                if (!ev_ok) begin
                  status <= ST_INVALID;
                  state  <= S_DONE;
                end else begin
                  next_link[cur_i] <= event_head[ev_i];
                  event_head[ev_i] <= current_id;
                  state <= S_BEST;
                end
              end
              MODE_SIGNAL: begin
                if (!ev_ok) begin
                  status <= ST_INVALID;
                  state  <= S_DONE;
                end else begin
                  walk <= event_head[ev_i];
                  event_head[ev_i] <= Nil;
                  state <= S_SIG_WALK;
                end
              end
              default: state <= S_BEST;
            endcase
          end
        end
        S_SIG_WALK: begin
          if (walk == Nil || 32'(value) >= MaxThreads) begin
            state <= S_RS_TICK;
          end else begin
            next_link[TW'(walk)] <= Nil;
            if (ready_head[walk_p] == Nil) ready_head[walk_p] <= walk;
            else next_link[TW'(ready_tail[walk_p])] <= walk;
            ready_tail[walk_p] <= walk;
            walk  <= next_link[TW'(walk)];
            value <= value + 1'b1;
          end
        end
        S_RS_TICK: begin
          expired <= (thread_ticks_left[cur_i] <= 8'd1);
          thread_ticks_left[cur_i] <= (thread_ticks_left[cur_i] <= 8'd1) ?
              slice_len : thread_ticks_left[cur_i] - 8'd1;
          state <= S_BEST;
        end
        S_BEST: if (!best_busy && !best_go) begin
          if (!best_found) begin
            if (after_wait) begin
              current_valid <= 1'b0;
              current_id <= '0;
              if (mode == MODE_WAIT) status <= ST_NO_RUN;
            end
            state <= S_DONE;
          end else begin
            ready_head[best_prio] <= next_link[TW'(cand)];
            if (next_link[TW'(cand)] == Nil) ready_tail[best_prio] <= Nil;
            lose <= cand;
            if (after_wait) begin
              current_id <= cand;
              state <= S_DONE;
            end else begin
              state <= S_RS_DECIDE;
            end
          end
        end
        S_RS_DECIDE: begin
          if (thread_priority[cur_i] < thread_priority[TW'(lose)] ||
              (expired && thread_priority[cur_i] == thread_priority[TW'(lose)])) begin
            lose <= current_id;
            current_id <= lose;
            state <= S_QBACK;
          end else begin
            state <= S_QFRONT;
          end
        end
        S_QBACK: begin
          next_link[TW'(lose)] <= Nil;
          if (ready_head[lose_p] == Nil) ready_head[lose_p] <= lose;
          else next_link[TW'(ready_tail[lose_p])] <= lose;
          ready_tail[lose_p] <= lose;
          state <= S_DONE;
        end
        S_QFRONT: begin
          next_link[TW'(lose)] <= ready_head[lose_p];
          if (ready_head[lose_p] == Nil) ready_tail[lose_p] <= lose;
          ready_head[lose_p] <= lose;
          state <= S_DONE;
        end
        S_DONE: if (res_load) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/prrts_best.sv -----
`default_nettype none
module prrts_best
  import prrts_pkg::*;
#(
  parameter int MaxPrio = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 go,
  input  wire logic [MaxPrio:0]     nonempty,
  output logic                      busy,
  output logic                      found,
  output logic [$clog2(MaxPrio+2)-1:0] prio
);
  // walks priorities from highest down, one per cycle
  localparam int PW = $clog2(MaxPrio + 2);
  logic [PW-1:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      found <= 1'b0;
      idx   <= '0;
      prio  <= '0;
    end else if (go) begin
      busy  <= 1'b1;
      found <= 1'b0;
      idx   <= PW'(MaxPrio);
    end else if (busy) begin
      if (nonempty[idx]) begin
        busy  <= 1'b0;
        found <= 1'b1;
        prio  <= idx;
      end else if (idx == '0) begin
        busy <= 1'b0;
      end else begin
        idx <= idx - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire
